// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands for the fusion block checkers.
// Relies on aclk and aresetn being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define IVSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define IVSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/ivsf_pkg.sv -----
// Shared constants and types for the inverse-variance sensor fusion block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ivsf_pkg;

    localparam int AXIS_W      = 2;
    localparam int ANGLE_W     = 32;
    localparam int SPREAD_W    = 32;
    localparam int RECIP_W     = 32;
    localparam int WEIGHT_W    = 32;
    localparam int NUM_SENSORS = 3;
    localparam int NUM_AXES    = 3;
    localparam int IDX_W       = 2;

    // divider: 64-bit dividend, 34-bit divisor, 32 quotient bits
    localparam int SUM_W     = 34;
    localparam int DVD_W     = 64;
    localparam int QUO_W     = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // weight bank, entry = axis*3 + sensor
    localparam int BANK_DEPTH = NUM_AXES * NUM_SENSORS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // accumulator and rounding
    localparam int ACC_W   = 64;
    localparam int Q_SHIFT = 31;
    localparam int RND_W   = ACC_W + 1 - Q_SHIFT;

    // stream word layout
    localparam int S_DATA_W = 200;
    localparam int S_USER_W = AXIS_W;
    localparam int M_DATA_W = ANGLE_W;
    localparam int M_USER_W = AXIS_W + 1;
    localparam int EN_LSB   = 3 * ANGLE_W + 3 * SPREAD_W;

    localparam logic [AXIS_W-1:0]  AXIS_NONE  = 2'd3;
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_SENSORS - 1);
    localparam logic [RECIP_W-1:0] RECIP_SAT  = '1;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [SUM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                 we;
        logic [BANK_AW-1:0]   addr;
        logic [WEIGHT_W-1:0]  data;
    } bank_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/ivsf_div.sv -----
// Shared restoring divider, one quotient bit per cycle; a start while busy is ignored.
// Depends on ivsf_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none

module ivsf_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ivsf_pkg::div_req_t req,
    output ivsf_pkg::div_rsp_t      rsp
);
    import ivsf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  dvs_reg;

    logic [SUM_W:0]    trial;
    logic              fits;

    // quotient bits shift in where dividend bits shift out
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // quotient known to fit 32 bits, so the top half starts as remainder
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg <= {{(SUM_W - (DVD_W - QUO_W)){1'b0}}, req.dividend[DVD_W-1:QUO_W]};
            quo_reg <= req.dividend[QUO_W-1:0];
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ivsf_bank.sv -----
// Per-axis normalized weight bank, 9 x 32 bits, cleared by reset.
// Depends on ivsf_pkg (bank_wr_t, widths).
`default_nettype none

module ivsf_bank (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ivsf_pkg::bank_wr_t              wr,
    input  wire logic [ivsf_pkg::BANK_AW-1:0]    rd_addr,
    output logic      [ivsf_pkg::WEIGHT_W-1:0]   rd_data
);
    import ivsf_pkg::*;

    logic [WEIGHT_W-1:0] weight_reg [BANK_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BANK_DEPTH; i++) begin
                weight_reg[i] <= '0;
            end
        end else if (wr.we) begin
            weight_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = weight_reg[rd_addr];

endmodule

`default_nettype wire

// ----- rtl/core/inverse_variance_sensor_fusion.sv -----
// Top level: inverse-sigma weighted fusion of three sensor angles per axis.
// Depends on ivsf_pkg, ivsf_div (shared divider), ivsf_bank (weight store).
//
//  channel | dir | tdata (low bit up)                          | tuser (low bit up)
//  s_      | in  | angle_a/b/c, spread_a/b/c, enable_a/b/c, pad | axis
//  m_      | out | fused_angle                                 | axis_out, no_data
//
// Each enabled sensor with sigma above one LSB needs a divide for its
// reciprocal, and each weight of an item with data needs another divide;
// all go through the one divider. The weighted sum then runs on one
// multiplier (multiply, then accumulate, per sensor), then rounding and
// the output register. Axis code 3 skips all work and goes straight to emit.
// Reset (aresetn low, synchronous) clears the weight bank and all control.
// s_tready is high only while idle; a finished result waits in the output
// register under m_ backpressure while the next word is already accepted.
`default_nettype none

module inverse_variance_sensor_fusion (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // angle_a, angle_b, angle_c, spread_a, spread_b, spread_c,
    // enable_a, enable_b, enable_c, zero pad
    input  wire logic [ivsf_pkg::S_DATA_W-1:0]   s_tdata,
    // axis
    input  wire logic [ivsf_pkg::S_USER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // fused_angle
    output logic      [ivsf_pkg::M_DATA_W-1:0]   m_tdata,
    // axis_out, no_data
    output logic      [ivsf_pkg::M_USER_W-1:0]   m_tuser
);
    import ivsf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RCP,
        ST_RCP_WAIT,
        ST_SUM,
        ST_WGT,
        ST_WGT_WAIT,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [AXIS_W-1:0]          axis_reg;
    logic signed [ANGLE_W-1:0]  angle_reg  [NUM_SENSORS];
    logic [SPREAD_W-1:0]        spread_reg [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]     en_reg;
    logic [RECIP_W-1:0]         recip_reg  [NUM_SENSORS];
    logic [SUM_W-1:0]           sum_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [ANGLE_W-1:0]         fused_reg;
    logic                       nodata_reg;
    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;
    logic [M_USER_W-1:0]        m_tuser_reg;

    div_req_t                   div_req;
    div_rsp_t                   div_rsp;
    bank_wr_t                   bank_wr;
    logic [BANK_AW-1:0]         bank_addr;
    logic [WEIGHT_W-1:0]        bank_rdata;

    logic                       need_div;
    logic signed [ANGLE_W:0]    mul_a;
    logic signed [ANGLE_W:0]    mul_b;
    logic signed [2*ANGLE_W+1:0] mul_p;
    logic signed [ACC_W:0]      rnd_sum;
    logic [RND_W-1:0]           rnd_q;
    logic                       rnd_ovf;
    logic [ANGLE_W-1:0]         rnd_sat;

    // divide only when the reciprocal does not saturate (sigma of 0 or 1 LSB)
    assign need_div = en_reg[idx_reg] && (spread_reg[idx_reg][SPREAD_W-1:1] != '0);

    assign bank_addr = BANK_AW'({2'b00, axis_reg} * 3) + BANK_AW'(idx_reg);

    // reciprocal: 2^32 / sigma; weight: r * 2^31 / sum
    always_comb begin
        div_req.start    = ((state_reg == ST_RCP) && need_div) || (state_reg == ST_WGT);
        if (state_reg == ST_WGT) begin
            div_req.dividend = {1'b0, recip_reg[idx_reg], {Q_SHIFT{1'b0}}};
            div_req.divisor  = sum_reg;
        end else begin
            div_req.dividend = DVD_W'(1) << QUO_W;
            div_req.divisor  = {{(SUM_W - SPREAD_W){1'b0}}, spread_reg[idx_reg]};
        end
    end

    assign bank_wr.we   = (state_reg == ST_WGT_WAIT) && div_rsp.done;
    assign bank_wr.addr = bank_addr;
    assign bank_wr.data = div_rsp.quotient;

    ivsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ivsf_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (bank_wr),
        .rd_addr (bank_addr),
        .rd_data (bank_rdata)
    );

    // signed angle times unsigned Q1.31 weight, 33 x 33 bits
    assign mul_a = {angle_reg[idx_reg][ANGLE_W-1], angle_reg[idx_reg]};
    assign mul_b = {1'b0, bank_rdata};
    assign mul_p = mul_a * mul_b;

    // round half up by 2^31, then clamp to 32 signed bits
    assign rnd_sum = {acc_reg[ACC_W-1], acc_reg} + (ACC_W + 1)'(64'h4000_0000);
    assign rnd_q   = rnd_sum[ACC_W:Q_SHIFT];
    assign rnd_ovf = (rnd_q[RND_W-1:ANGLE_W-1] != '0) && (rnd_q[RND_W-1:ANGLE_W-1] != '1);
    always_comb begin
        if (rnd_ovf) begin
            rnd_sat = rnd_q[RND_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
            rnd_sat = rnd_q[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the emit state owns the output register while it loads
            if (m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        axis_reg <= s_tuser;
                        for (int i = 0; i < NUM_SENSORS; i++) begin
                            angle_reg[i]  <= s_tdata[i*ANGLE_W +: ANGLE_W];
                            spread_reg[i] <= s_tdata[NUM_SENSORS*ANGLE_W + i*SPREAD_W +: SPREAD_W];
                            en_reg[i]     <= s_tdata[EN_LSB + i];
                        end
                        idx_reg <= '0;
                        if (s_tuser == AXIS_NONE) begin
                            fused_reg  <= '0;
                            nodata_reg <= 1'b1;
                            state_reg  <= ST_EMIT;
                        end else begin
                            state_reg  <= ST_RCP;
                        end
                    end
                end
                ST_RCP: begin
                    if (need_div) begin
                        state_reg <= ST_RCP_WAIT;
                    end else begin
                        recip_reg[idx_reg] <= en_reg[idx_reg] ? RECIP_SAT : '0;
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_SUM;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_RCP_WAIT: begin
                    if (div_rsp.done) begin
                        recip_reg[idx_reg] <= div_rsp.quotient;
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_SUM;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_RCP;
                        end
                    end
                end
                ST_SUM: begin
                    // an enabled sensor always has r >= 1, so sum is zero iff none enabled
                    sum_reg    <= SUM_W'(recip_reg[0]) + SUM_W'(recip_reg[1])
                                  + SUM_W'(recip_reg[2]);
                    nodata_reg <= (en_reg == '0);
                    idx_reg    <= '0;
                    acc_reg    <= '0;
                    state_reg  <= (en_reg == '0) ? ST_MUL : ST_WGT;
                end
                ST_WGT: begin
                    state_reg <= ST_WGT_WAIT;
                end
                ST_WGT_WAIT: begin
                    if (div_rsp.done) begin
                        if (idx_reg == LAST_IDX) begin
                            idx_reg   <= '0;
                            state_reg <= ST_MUL;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_WGT;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_p[ACC_W-1:0];
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= acc_reg + prod_reg;
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_RND;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_RND: begin
                    fused_reg <= rnd_sat;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= fused_reg;
                        m_tuser_reg  <= {nodata_reg, axis_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ivsf_checker.sv -----
// Port-level checks for the fusion block, bound to the top level.
// Depends on ivsf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ivsf_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ivsf_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic [ivsf_pkg::M_USER_W-1:0]   m_tuser
);
    import ivsf_pkg::*;

    logic [AXIS_W-1:0] m_axis;
    logic              m_nodata;

    assign m_axis   = m_tuser[AXIS_W-1:0];
    assign m_nodata = m_tuser[AXIS_W];

    // one word in flight: input closes right after an accept
    `IVSF_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "s_tready high after accept")
    // missing axis bank answers zero with no_data
    `IVSF_ASSERT(a_axis_none, m_tvalid && (m_axis == AXIS_NONE) |-> m_nodata && (m_tdata == '0), "bad axis 3")
    // a held result keeps its word
    `IVSF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}), "held word lost")
    // reset empties the output register
    `IVSF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "m_tvalid after reset")

endmodule

bind inverse_variance_sensor_fusion ivsf_checker u_ivsf_checker (.*);

`default_nettype wire

// ----- tb/fusion_tb_pkg.sv -----
// Testbench types for the sensor fusion block: the input word layout and axis codes.
// Depends on nothing. It is shared by the checker and the testbench top.
`timescale 1ns / 1ps

package fusion_tb_pkg;

    typedef enum logic [1:0] {
        AX_ROLL    = 2'd0,
        AX_PITCH   = 2'd1,
        AX_HEADING = 2'd2,
        AX_NONE    = 2'd3
    } axis_e;

    // s_tdata layout; the last member sits in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic               en_c;
        logic               en_b;
        logic               en_a;
        logic [31:0]        spread_c;
        logic [31:0]        spread_b;
        logic [31:0]        spread_a;
        logic signed [31:0] angle_c;
        logic signed [31:0] angle_b;
        logic signed [31:0] angle_a;
    } sensor_word_t;

endpackage

// ----- tb/fusion_checker.sv -----
// Scoreboard for the fusion block: it watches both stream channels and predicts each fused word.
// It compares the words field by field. Depends on ivsf_pkg and fusion_tb_pkg.
`timescale 1ns / 1ps

module fusion_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ivsf_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [ivsf_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ivsf_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [ivsf_pkg::M_USER_W-1:0]    m_tuser,
    output int                               fail_count,
    output int                               pending,
    output int                               results_seen,
    output int                               no_data_seen
);
    import fusion_tb_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] fused;
        logic               no_data;
    } fused_result_t;

    // Q1.31 weights, entry = axis*3 + sensor
    logic [31:0]   weight_bank [ivsf_pkg::BANK_DEPTH];
    fused_result_t fused_q [$];
    int            mism = 0;
    int            n_res = 0;
    int            n_nodata = 0;

    // Q16.16 reciprocal, saturating; zero and one LSB both pin to all ones
    function automatic logic [31:0] recip_q16(input logic [31:0] spread);
        logic [32:0] quo;
        if (spread == '0)
            return 32'hFFFF_FFFF;
        quo = 33'h1_0000_0000 / {1'b0, spread};
        return (quo > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    // Updates the weight bank and returns the expected fused word
    function automatic fused_result_t fuse_word(input sensor_word_t w, input logic [1:0] ax);
        logic [31:0]   ang [3];
        logic [31:0]   spr [3];
        logic          en  [3];
        logic [31:0]   raw [3];
        logic [33:0]   total;
        longint        acc;
        logic [63:0]   biased;
        longint        q;
        fused_result_t res;
        ang = '{w.angle_a, w.angle_b, w.angle_c};
        spr = '{w.spread_a, w.spread_b, w.spread_c};
        en  = '{w.en_a, w.en_b, w.en_c};
        total = '0;
        for (int i = 0; i < 3; i++) begin
            raw[i] = en[i] ? recip_q16(spr[i]) : 32'd0;
            total += {2'b00, raw[i]};
        end
        res.axis = ax;
        if (ax == AX_NONE) begin
            res.fused   = '0;
            res.no_data = 1'b1;
            return res;
        end
        if (total != '0) begin
            for (int i = 0; i < 3; i++)
                weight_bank[ax*3 + i] = 32'(64'({raw[i], 31'b0}) / 64'(total));
        end
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += longint'($signed(ang[i])) * longint'({1'b0, weight_bank[ax*3 + i]});
        // bias to unsigned, add half an LSB, shift: round half toward +inf
        biased = 64'(acc) + 64'h4000_0000_0000_0000 + 64'h0000_0000_4000_0000;
        q = longint'(biased >> 31) - 64'sd2147483648;
        if (q > Q_MAX) q = Q_MAX;
        if (q < Q_MIN) q = Q_MIN;
        res.fused   = q[31:0];
        res.no_data = (total == '0);
        return res;
    endfunction

    always @(posedge aclk) begin : mon
        fused_result_t got;
        fused_result_t want;
        if (!aresetn) begin
            fused_q.delete();
            for (int i = 0; i < ivsf_pkg::BANK_DEPTH; i++)
                weight_bank[i] = '0;
        end else begin
            if (s_tvalid && s_tready)
                fused_q.push_back(fuse_word(sensor_word_t'(s_tdata), s_tuser));
            if (m_tvalid && m_tready) begin
                got.axis    = m_tuser[1:0];
                got.fused   = m_tdata;
                got.no_data = m_tuser[2];
                n_res++;
                if (got.no_data)
                    n_nodata++;
                if (fused_q.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("%0t ERROR unexpected word: axis %0d fused %h no_data %b",
                                 $time, got.axis, got.fused, got.no_data);
                end else begin
                    want = fused_q.pop_front();
                    if (got.axis != want.axis || got.fused != want.fused
                            || got.no_data != want.no_data) begin
                        mism++;
                        if (mism <= 10)
                            $display({"%0t ERROR word %0d: expected axis %0d fused %h ",
                                      "no_data %b, got axis %0d fused %h no_data %b"},
                                     $time, n_res, want.axis, want.fused, want.no_data,
                                     got.axis, got.fused, got.no_data);
                    end
                end
            end
        end
        fail_count   <= mism;
        pending      <= fused_q.size();
        results_seen <= n_res;
        no_data_seen <= n_nodata;
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for inverse_variance_sensor_fusion: drives sensor words, throttles the result side.
// It gives the verdict. Depends on ivsf_pkg, fusion_tb_pkg and fusion_checker.
`timescale 1ns / 1ps

module tb_top;
    import fusion_tb_pkg::*;

    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [31:0] HALF_Q16    = 32'h0000_8000;
    localparam logic [31:0] SPREAD_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] ANGLE_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] ANGLE_MIN   = 32'h8000_0000;
    localparam logic [31:0] ONE_Q28     = 32'h1000_0000;
    localparam logic [31:0] NEG_ONE_Q28 = 32'hF000_0000;
    localparam logic [31:0] NEG_LSB     = 32'hFFFF_FFFF;
    localparam int          HOLD_CYCLES = 700;
    localparam int          DRAIN_CYCLES = 250;  // well above one worst-case word

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ivsf_pkg::S_DATA_W-1:0]    s_tdata  = '0;
    logic [ivsf_pkg::S_USER_W-1:0]    s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ivsf_pkg::M_DATA_W-1:0]    m_tdata;
    logic [ivsf_pkg::M_USER_W-1:0]    m_tuser;

    int   fail_count;
    int   pending;
    int   results_seen;
    int   no_data_seen;

    int   send_idle_pct = 0;   // used by the stimulus process only
    int   recv_idle_pct = 0;   // changed by NBA, read by the receiver process
    int   words_sent    = 0;
    logic hold_go       = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    inverse_variance_sensor_fusion i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fusion_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .no_data_seen (no_data_seen)
    );

    // Result side. A single long hold-off is counted down here while the
    // sender keeps offering words: the block takes one more word, parks its
    // result in the output register, then drops s_tready until the hold ends.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one word and waits for its handshake. tvalid only drops ahead of
    // a gap, so back-to-back words never see a low/high pair in one step.
    // en[0] is sensor A, en[1] B, en[2] C.
    task automatic send_word(input logic [1:0] ax, input logic [2:0] en,
                             input logic [31:0] ang_a, ang_b, ang_c,
                             input logic [31:0] sig_a, sig_b, sig_c);
        sensor_word_t word;
        word = '{pad: '0, en_c: en[2], en_b: en[1], en_a: en[0],
                 spread_c: sig_c, spread_b: sig_b, spread_a: sig_a,
                 angle_c: ang_c, angle_b: ang_b, angle_a: ang_a};
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= ax;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // Sigmas: mostly ordinary Q16.16 values, with zero, one LSB and the
    // maximum (reciprocal of one) mixed in, plus fully random bit patterns.
    function automatic logic [31:0] pick_spread();
        case ($urandom_range(15))
            0:       return '0;
            1:       return 32'd1;
            2:       return SPREAD_MAX;
            3, 4:    return $urandom;
            default: return $urandom_range(32'h0004_0000, 32'h0000_0100);
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(7))
            0:       return ANGLE_MAX;
            1:       return ANGLE_MIN;
            2, 3:    return $signed($urandom) >>> $urandom_range(24);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int n_words);
        logic [1:0] ax;
        logic [2:0] en;
        for (int n = 0; n < n_words; n++) begin
            // axis code 3 now and then; all sensors off a bit more often
            // than the plain 1-in-8 so bank reuse is exercised
            ax = ($urandom_range(99) < 5) ? AX_NONE : 2'($urandom_range(2));
            en = ($urandom_range(99) < 8) ? 3'b000 : 3'($urandom_range(7));
            send_word(ax, en, pick_angle(), pick_angle(), pick_angle(),
                      pick_spread(), pick_spread(), pick_spread());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // profile 1: sender idles 28%, receiver 51%
        send_idle_pct = 28;
        recv_idle_pct <= 51;

        // Directed words.
        // No sensors enabled right after reset: the bank is empty, so fused is 0.
        send_word(AX_ROLL, 3'b000, ANGLE_MAX, ANGLE_MIN, 32'd1, ONE_Q16, ONE_Q16, ONE_Q16);
        // Axis code 3 with all sensors enabled: nothing is stored.
        send_word(AX_NONE, 3'b111, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ONE_Q16, ONE_Q16, ONE_Q16);
        // Sensor A alone takes full weight; disabled sensors have a zero sigma.
        send_word(AX_ROLL, 3'b001, ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ONE_Q16, '0, '0);
        // No data: the stored roll weights are reused on new angles.
        send_word(AX_ROLL, 3'b000, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, '0, '0, '0);
        // Zero sigma on the only enabled sensor saturates its reciprocal.
        send_word(AX_PITCH, 3'b010, '0, ANGLE_MIN, ANGLE_MAX, ONE_Q16, '0, ONE_Q16);
        // Zero and one-LSB sigmas both saturate and tie against each other.
        send_word(AX_PITCH, 3'b111, ONE_Q28, NEG_ONE_Q28, 32'h0800_0000,
                  '0, 32'd1, ONE_Q16);
        // Largest sigma: each raw weight is one LSB.
        send_word(AX_HEADING, 3'b111, ONE_Q28, 32'h0123_4567, NEG_ONE_Q28,
                  SPREAD_MAX, SPREAD_MAX, SPREAD_MAX);
        send_word(AX_HEADING, 3'b100, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN,
                  '0, '0, SPREAD_MAX);
        send_word(AX_HEADING, 3'b101, 32'h0ABC_DEF0, '0, 32'hF543_2100,
                  32'h0000_0100, ONE_Q16, 32'h0010_0000);
        // Rounding ties: +1/2 LSB goes up, -1/2 LSB goes to zero.
        send_word(AX_ROLL, 3'b011, 32'd1, '0, ANGLE_MAX, ONE_Q16, ONE_Q16, ONE_Q16);
        send_word(AX_ROLL, 3'b011, NEG_LSB, '0, ANGLE_MIN, ONE_Q16, ONE_Q16, ONE_Q16);
        // Reuse of the equal roll weights and of the pitch bank.
        send_word(AX_ROLL, 3'b000, 32'd3, 32'd5, 32'd7, '0, '0, '0);
        send_word(AX_PITCH, 3'b000, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, '0, '0, '0);
        // Full-scale angles on all three sensors, both signs.
        send_word(AX_HEADING, 3'b111, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX,
                  ONE_Q16, ONE_Q16, ONE_Q16);
        send_word(AX_HEADING, 3'b111, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, '0, '0, '0);
        send_word(AX_NONE, 3'b000, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN,
                  SPREAD_MAX, SPREAD_MAX, SPREAD_MAX);
        send_word(AX_PITCH, 3'b110, ONE_Q28, NEG_ONE_Q28, ONE_Q28,
                  ONE_Q16, HALF_Q16, 32'h0003_0000);
        send_word(AX_ROLL, 3'b111, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001,
                  32'h0000_4000, 32'h0002_8000, 32'h0000_0002);

        run_random(185);

        // profile 2: sender idles 51%, receiver 28%
        send_idle_pct = 51;
        recv_idle_pct <= 28;
        run_random(185);

        // profile 3: no idling; the long receiver hold-off lands here
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_go <= 1'b1;
        run_random(180);

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered: %0d sensor words over three idle profiles and a %0d-cycle hold-off;",
                 words_sent, HOLD_CYCLES);
        $display("         %0d fused words compared, %0d of them flagged without sensor data.",
                 results_seen, no_data_seen);
        if (fail_count == 0 && pending == 0)
            $display("inverse_variance_sensor_fusion: match");
        else
            $display("inverse_variance_sensor_fusion: mismatch");
        $finish;
    end

    // Watchdog, many times the slowest passing run.
    initial begin
        #2_000_000;
        $display("inverse_variance_sensor_fusion: mismatch");
        $finish;
    end

endmodule
